// ----- src/fcrq_pkg.sv -----
`timescale 1ns / 1ps

package fcrq_pkg;

   // Field widths of one item
   localparam int ActW    = 8;
   localparam int WordW   = 32;
   localparam int GroupW  = 6;
   localparam int ChanW   = 8;
   localparam int ProdW   = 24;   // int8 x int16
   localparam int ReqShift = 30;

   // Register file
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 9;
   localparam int GcW      = 7;
   localparam int OcW      = 9;

   localparam logic [CsrIdxW-1:0] CSR_GROUP_COUNT  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_OUTPUT_COUNT = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_RELU_MODE    = 2'd2;

   // Item operation codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_WEIGHT = 1'b1;

   // Clamp limits
   localparam logic signed [WordW-1:0] ClampHi = 32'sd127;
   localparam logic signed [WordW-1:0] ClampLo = -32'sd128;

   typedef struct packed {
      logic                     operation;
      logic [GroupW-1:0]        group_index;
      logic signed [ActW-1:0]   act_zero;
      logic signed [ActW-1:0]   act_one;
      logic signed [ActW-1:0]   act_two;
      logic signed [ActW-1:0]   act_three;
      logic [WordW-1:0]         weight_even;
      logic [WordW-1:0]         weight_odd;
      logic signed [WordW-1:0]  bias;
      logic signed [WordW-1:0]  scale_multiplier;
   } req_type;

   typedef struct packed {
      logic signed [ActW-1:0] out_value;
      logic [ChanW-1:0]       channel_index;
   } rsp_type;

   typedef struct packed {
      logic prod_en;     // capture the four products
      logic acc_en;      // fold products into the accumulator
      logic seed_bias;   // restart from bias (group zero)
   } mac_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD,
      ST_ACC,
      ST_SCALE,
      ST_CLAMP
   } state_type;

endpackage

// ----- src/int8_fc_layer_requant_core.sv -----
`timescale 1ns / 1ps

// int8 fully connected layer with fixed-shift requantization.
//
// Input channel: an item (req_item) is taken at a rising edge with start high
// and busy low. A load item writes four activations into the activation
// memory in that same edge; busy stays low, so another item may follow in
// the next cycle. A weight item reads its activation group from the memory
// and holds busy through the product (ST_PROD) and accumulate (ST_ACC)
// states. The last group of a channel also passes through ST_SCALE and
// ST_CLAMP; its result shows on rsp_item with rsp_strobe high for one cycle,
// loaded from ST_CLAMP into the result register. Rate is set by the memory
// read and the product and accumulate registers, plus the scale-multiply
// and result registers for a last group; one item walks through them in turn.
// The result channel has no back-pressure: each result is valid for one
// cycle only and the receiver must take it then.
// Configuration: csr_write_enable/csr_index/csr_write_data write one register
// per edge; index 3 is ignored. The user must write only while the block
// is idle; the block does not enforce it. Reset (synchronous): accumulator
// and channel counter clear; group and output counts go to 1, relu_mode to 0.
// Activation memory is not cleared; a group must be loaded before it is used.

module int8_fc_layer_requant_core #(
   parameter int MAX_GROUPS  = 64,
   parameter int MAX_OUTPUTS = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  fcrq_pkg::req_type              req_item,
   output logic                           rsp_strobe,
   output fcrq_pkg::rsp_type              rsp_item,
   input  logic                           csr_write_enable,
   input  logic [fcrq_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [fcrq_pkg::CsrDataW-1:0]  csr_write_data
);
   import fcrq_pkg::*;

   localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

   // config registers
   logic [GcW-1:0] group_count_ff;
   logic [OcW-1:0] output_count_ff;
   logic           relu_mode_ff;

   state_type   state_ff, state_in;
   req_type     req_ff;
   logic        zero_ff;
   logic [ChanW-1:0] chan_ff, chan_in;
   rsp_type     rsp_ff;
   logic        strobe_ff;

   logic        accept;
   logic        in_range;
   logic [AW-1:0] addr;
   logic [WordW-1:0] act_word, rd_data;
   logic        last_group;
   logic [GcW-1:0] gc_eff;
   logic [OcW-1:0] oc_eff, chan_next;
   mac_ctl_type mac_ctl;
   logic        mul_en;
   logic        out_load;
   logic signed [WordW-1:0] acc;
   logic signed [ActW-1:0]  req_value;

   assign accept   = start && !busy;
   assign in_range = 32'(req_item.group_index) < MAX_GROUPS;
   assign addr     = AW'(req_item.group_index);
   assign act_word = {req_item.act_three, req_item.act_two,
                      req_item.act_one, req_item.act_zero};

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         group_count_ff  <= GcW'(1);
         output_count_ff <= OcW'(1);
         relu_mode_ff    <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_GROUP_COUNT:  group_count_ff  <= csr_write_data[GcW-1:0];
            CSR_OUTPUT_COUNT: output_count_ff <= csr_write_data[OcW-1:0];
            CSR_RELU_MODE:    relu_mode_ff    <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // zero counts act as 1, large counts saturate
   assign gc_eff = (group_count_ff == '0) ? GcW'(1) :
                   (32'(group_count_ff) > MAX_GROUPS) ? GcW'(MAX_GROUPS) :
                   group_count_ff;
   assign oc_eff = (output_count_ff == '0) ? OcW'(1) :
                   (32'(output_count_ff) > MAX_OUTPUTS) ? OcW'(MAX_OUTPUTS) :
                   output_count_ff;

   assign last_group = ({1'b0, req_ff.group_index} == gc_eff - GcW'(1));

   // ---- activation memory ----
   fcrq_ram #(
      .WIDTH (WordW),
      .DEPTH (MAX_GROUPS)
   ) u_act_ram (
      .clock   (clock),
      .wr_en   (accept && (req_item.operation == OP_LOAD) && in_range),
      .wr_addr (addr),
      .wr_data (act_word),
      .rd_en   (accept && (req_item.operation == OP_WEIGHT)),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   // capture the weight item; payload needs no reset
   always_ff @(posedge clock) begin
      if (accept && (req_item.operation == OP_WEIGHT)) begin
         req_ff  <= req_item;
         zero_ff <= !in_range;
      end
   end

   fcrq_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .ctl         (mac_ctl),
      .acts        (rd_data),
      .acts_zero   (zero_ff),
      .weight_even (req_ff.weight_even),
      .weight_odd  (req_ff.weight_odd),
      .bias        (req_ff.bias),
      .acc         (acc)
   );

   fcrq_requant u_requant (
      .clock      (clock),
      .mul_en     (mul_en),
      .relu_mode  (relu_mode_ff),
      .acc        (acc),
      .multiplier (req_ff.scale_multiplier),
      .value      (req_value)
   );

   // ---- sequencer: next state ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_item.operation == OP_WEIGHT)) begin
               state_in = ST_PROD;
            end
         end
         ST_PROD:  state_in = ST_ACC;
         ST_ACC:   state_in = last_group ? ST_SCALE : ST_IDLE;
         ST_SCALE: state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---- sequencer: outputs ----
   always_comb begin
      mac_ctl  = '0;
      mul_en   = 1'b0;
      out_load = 1'b0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_PROD: mac_ctl.prod_en = 1'b1;
         ST_ACC: begin
            mac_ctl.acc_en    = 1'b1;
            mac_ctl.seed_bias = (req_ff.group_index == '0);
         end
         ST_SCALE: mul_en = 1'b1;
         ST_CLAMP: out_load = 1'b1;
         default: busy = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---- channel counter and result register ----
   assign chan_next = OcW'(chan_ff) + OcW'(1);

   always_comb begin
      chan_in = chan_ff;
      if (out_load) begin
         chan_in = (chan_next >= oc_eff) ? '0 : chan_next[ChanW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         chan_ff   <= chan_in;
         strobe_ff <= out_load;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff.out_value     <= req_value;
         rsp_ff.channel_index <= chan_ff;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ----- src/fcrq_ram.sv -----
`timescale 1ns / 1ps

module fcrq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/fcrq_mac.sv -----
`timescale 1ns / 1ps

module fcrq_mac (
   input  logic                             clock,
   input  logic                             reset,
   input  fcrq_pkg::mac_ctl_type            ctl,
   input  logic [fcrq_pkg::WordW-1:0]       acts,
   input  logic                             acts_zero,
   input  logic [fcrq_pkg::WordW-1:0]       weight_even,
   input  logic [fcrq_pkg::WordW-1:0]       weight_odd,
   input  logic signed [fcrq_pkg::WordW-1:0] bias,
   output logic signed [fcrq_pkg::WordW-1:0] acc
);
   import fcrq_pkg::*;

   logic [WordW-1:0]         act_word;
   logic signed [ActW-1:0]   a0, a1, a2, a3;
   logic signed [ProdW-1:0]  prod_in [4];
   logic signed [ProdW-1:0]  prod_ff [4];
   logic signed [WordW-1:0]  psum;
   logic signed [WordW-1:0]  acc_in, acc_ff;

   // out-of-range group reads as zero activations
   assign act_word = acts_zero ? '0 : acts;
   assign a0 = act_word[7:0];
   assign a1 = act_word[15:8];
   assign a2 = act_word[23:16];
   assign a3 = act_word[31:24];

   assign prod_in[0] = a0 * $signed(weight_even[15:0]);
   assign prod_in[1] = a2 * $signed(weight_even[31:16]);
   assign prod_in[2] = a1 * $signed(weight_odd[15:0]);
   assign prod_in[3] = a3 * $signed(weight_odd[31:16]);

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         prod_ff <= prod_in;
      end
   end

   assign psum = WordW'(prod_ff[0]) + WordW'(prod_ff[1])
               + WordW'(prod_ff[2]) + WordW'(prod_ff[3]);

   always_comb begin
      acc_in = acc_ff;
      if (ctl.acc_en) begin
         acc_in = (ctl.seed_bias ? bias : acc_ff) + psum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ----- src/fcrq_requant.sv -----
`timescale 1ns / 1ps

module fcrq_requant (
   input  logic                              clock,
   input  logic                              mul_en,
   input  logic                              relu_mode,
   input  logic signed [fcrq_pkg::WordW-1:0] acc,
   input  logic signed [fcrq_pkg::WordW-1:0] multiplier,
   output logic signed [fcrq_pkg::ActW-1:0]  value
);
   import fcrq_pkg::*;

   logic signed [2*WordW-1:0] prod_ff;
   logic signed [WordW-1:0]   shifted;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= acc * multiplier;
      end
   end

   // arithmetic shift by 30, low 32 bits kept
   assign shifted = prod_ff[ReqShift +: WordW];

   always_comb begin
      if (relu_mode) begin
         if (shifted < 0) begin
            value = '0;
         end else if (shifted > ClampHi) begin
            value = ActW'(ClampHi);
         end else begin
            value = shifted[ActW-1:0];
         end
      end else begin
         if (shifted > ClampHi) begin
            value = ActW'(ClampHi);
         end else if (shifted < ClampLo) begin
            value = ActW'(ClampLo);
         end else begin
            value = shifted[ActW-1:0];
         end
      end
   end

endmodule

// ----- src/fcrq_checker.sv -----
`timescale 1ns / 1ps

module fcrq_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input fcrq_pkg::req_type req_item,
   input logic              rsp_strobe
);
   import fcrq_pkg::*;

   // a result follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without preceding work");

   // results never come back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in a row");

   // loads complete in the accepting edge
   a_load_no_stall: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.operation == OP_LOAD)) |=> !busy)
      else $error("load item stalled the block");

   // weight items keep the block busy after acceptance, not finishing at once
   a_weight_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.operation == OP_WEIGHT)) |=> busy ##1 busy)
      else $error("weight item finished too early");

endmodule

bind int8_fc_layer_requant_core fcrq_checker u_fcrq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe)
);
